[rtl/utf8_utf16_transcoder_assert.svh]
// ----------------------------------------------------------------------------
// UTF-8 / UTF-16 transcoder assertion macros
// Shared helpers for concurrent checks on clocked signals.
// ----------------------------------------------------------------------------
`ifndef UTF8_UTF16_TRANSCODER_ASSERT_SVH
`define UTF8_UTF16_TRANSCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8U16_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("transcoder check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("transcoder check failed: next-cycle implication");

`endif

[rtl/u8u16_pkg.sv]
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types and constants shared by the transcoder front end, job queue and back end.
// ----------------------------------------------------------------------------
package u8u16_pkg;

	localparam int UnitW  = 16;
	localparam int ByteW  = 8;
	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);

	localparam logic DIR_DECODE = 1'b0;
	localparam logic DIR_ENCODE = 1'b1;

	// One classified item, waiting for the back end to expand it.
	typedef struct packed {
		logic             enc;     // encode job: data is a raw UTF-16 unit
		logic [1:0]       nres;    // number of results, 1..3
		logic [UnitW-1:0] data;    // decoded unit or unit to encode
		logic             eos;     // item closed its string
		logic             trunc;   // string ended inside a sequence
	} job_t;

endpackage

[rtl/u8u16_front.sv]
// ----------------------------------------------------------------------------
// u8u16_front
// Accepts input beats, runs the UTF-8 sequence tracker and queues one job per
// item that yields results.
// ----------------------------------------------------------------------------
module u8u16_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_data,
	input  logic                      push,
	output logic                      full,
	input  logic [u8u16_pkg::UnitW-1:0] unit_in,
	input  logic                      string_end,
	input  logic                      q_full,
	output logic                      job_push,
	output u8u16_pkg::job_t           job
);
	import u8u16_pkg::*;

	logic             dir_q;
	logic [1:0]       pend_q;
	logic [UnitW-1:0] acc_q;

	logic             accept;
	logic [ByteW-1:0] b;
	logic [1:0]       pend_nxt;
	logic [UnitW-1:0] acc_nxt;
	logic             emit;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign accept    = push && !q_full;
	assign b         = unit_in[ByteW-1:0];

	always_comb begin
		pend_nxt   = pend_q;
		acc_nxt    = acc_q;
		emit       = 1'b0;
		job        = '0;
		job.eos    = string_end;
		if (dir_q == DIR_ENCODE) begin
			emit     = 1'b1;
			job.enc  = 1'b1;
			job.data = unit_in;
			if (unit_in <= 16'h007F) begin
				job.nres = 2'd1;
			end else if (unit_in <= 16'h07FF) begin
				job.nres = 2'd2;
			end else begin
				job.nres = 2'd3;
			end
		end else begin
			job.nres = 2'd1;
			if (pend_q == 2'd0 && b <= 8'h7F) begin
				emit     = 1'b1;
				job.data = {8'h00, b};
			end else if (pend_q == 2'd0 || pend_q == 2'd2) begin
				if (pend_q == 2'd2) begin
					acc_nxt  = acc_q | {4'h0, b[5:0], 6'h00};
					pend_nxt = 2'd1;
				end else if (b <= 8'hDF) begin
					acc_nxt  = {5'h00, b[4:0], 6'h00};
					pend_nxt = 2'd1;
				end else begin
					acc_nxt  = {b[3:0], 12'h000};
					pend_nxt = 2'd2;
				end
				// string closed mid-sequence: flush what was gathered
				if (string_end) begin
					emit      = 1'b1;
					job.data  = acc_nxt;
					job.trunc = 1'b1;
					acc_nxt   = '0;
					pend_nxt  = 2'd0;
				end
			end else begin
				emit     = 1'b1;
				job.data = acc_q | {10'h000, b[5:0]};
				acc_nxt  = '0;
				pend_nxt = 2'd0;
			end
		end
	end

	assign job_push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= DIR_DECODE;
			pend_q <= 2'd0;
			acc_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			dir_q  <= cfg_data;
			pend_q <= 2'd0;
			acc_q  <= '0;
		end else if (accept && dir_q == DIR_DECODE) begin
			pend_q <= pend_nxt;
			acc_q  <= acc_nxt;
		end
	end

endmodule

[rtl/u8u16_fifo.sv]
// ----------------------------------------------------------------------------
// u8u16_fifo
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module u8u16_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  u8u16_pkg::job_t wr_data,
	output logic            q_full,
	input  logic            rd_en,
	output u8u16_pkg::job_t rd_data,
	output logic            q_avail
);
	import u8u16_pkg::*;

	job_t            mem_q [QDepth];
	logic [QAw-1:0]  wptr_q;
	logic [QAw-1:0]  rptr_q;
	logic [QAw:0]    cnt_q;
	logic            do_wr;
	logic            do_rd;

	assign q_full  = (cnt_q == QAw'(0) + (QAw+1)'(QDepth));
	assign q_avail = (cnt_q != '0);
	assign rd_data = mem_q[rptr_q];
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && q_avail;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + QAw'(1);
			end
			if (do_rd) begin
				rptr_q <= rptr_q + QAw'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + (QAw+1)'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - (QAw+1)'(1);
			end
		end
	end

endmodule

[rtl/u8u16_back.sv]
// ----------------------------------------------------------------------------
// u8u16_back
// Expands jobs into beats in an output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module u8u16_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_avail,
	input  u8u16_pkg::job_t             job,
	output logic                        job_pop,
	output logic                        empty,
	input  logic                        pop,
	output logic [u8u16_pkg::UnitW-1:0] unit_out,
	output logic                        last_of_input,
	output logic                        truncated,
	output logic                        string_done
);
	import u8u16_pkg::*;

	logic             out_valid_q;
	logic [UnitW-1:0] unit_q;
	logic             last_q;
	logic             trunc_q;
	logic             done_q;
	logic [1:0]       idx_q;

	logic             load;
	logic             is_last;
	logic [ByteW-1:0] byte_v;
	logic [UnitW-1:0] res_unit;

	assign load    = q_avail && (!out_valid_q || pop);
	assign is_last = (idx_q == job.nres - 2'd1);
	assign job_pop = load && is_last;

	always_comb begin
		byte_v = '0;
		case (job.nres)
			2'd1: byte_v = {1'b0, job.data[6:0]};
			2'd2: begin
				if (idx_q == 2'd0) begin
					byte_v = {3'b110, job.data[10:6]};
				end else begin
					byte_v = {2'b10, job.data[5:0]};
				end
			end
			2'd3: begin
				case (idx_q)
					2'd0:    byte_v = {4'b1110, job.data[15:12]};
					2'd1:    byte_v = {2'b10, job.data[11:6]};
					default: byte_v = {2'b10, job.data[5:0]};
				endcase
			end
			default: byte_v = '0;
		endcase
		res_unit = job.enc ? {8'h00, byte_v} : job.data;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			unit_q  <= res_unit;
			last_q  <= is_last;
			trunc_q <= job.trunc;
			done_q  <= is_last && job.eos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty         = !out_valid_q;
	assign unit_out      = unit_q;
	assign last_of_input = last_q;
	assign truncated     = trunc_q;
	assign string_done   = done_q;

endmodule

[rtl/utf8_utf16_transcoder.sv]
// ----------------------------------------------------------------------------
// utf8_utf16_transcoder
// UTF-8 to UTF-16 (BMP) decoder and UTF-16 to UTF-8 encoder with a front end,
// a four-job queue and a result back end.
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------------------
//   input    | push / full        | unit_in, string_end
//   result   | empty / pop        | unit_out, last_of_input, truncated, string_done
//   config   | cfg_valid/cfg_ready| cfg_data (direction)
//
// One input beat per cycle while full is low; its first result passes through the
// job queue and then the output register before it reaches the result ports.
// The back end emits one result beat per cycle unless its output is stalled, so a
// two- or three-byte encoding holds it to the last byte; the queue absorbs that.
// full follows the job queue; a stalled result register backs up into it.
// Reset clears direction, decoder state, queue and output valid flag; no init pass.
// ----------------------------------------------------------------------------
module utf8_utf16_transcoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_data,
	input  logic                        push,
	output logic                        full,
	input  logic [u8u16_pkg::UnitW-1:0] unit_in,
	input  logic                        string_end,
	output logic                        empty,
	input  logic                        pop,
	output logic [u8u16_pkg::UnitW-1:0] unit_out,
	output logic                        last_of_input,
	output logic                        truncated,
	output logic                        string_done
);
	import u8u16_pkg::*;

	job_t wr_job;
	job_t head_job;
	logic job_push;
	logic job_pop;
	logic q_full;
	logic q_avail;

	u8u16_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.push       (push),
		.full       (full),
		.unit_in    (unit_in),
		.string_end (string_end),
		.q_full     (q_full),
		.job_push   (job_push),
		.job        (wr_job)
	);

	u8u16_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (wr_job),
		.q_full  (q_full),
		.rd_en   (job_pop),
		.rd_data (head_job),
		.q_avail (q_avail)
	);

	u8u16_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_avail       (q_avail),
		.job           (head_job),
		.job_pop       (job_pop),
		.empty         (empty),
		.pop           (pop),
		.unit_out      (unit_out),
		.last_of_input (last_of_input),
		.truncated     (truncated),
		.string_done   (string_done)
	);

endmodule

[rtl/u8u16_checker.sv]
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level checks on the transcoder result channel.
// ----------------------------------------------------------------------------
`include "utf8_utf16_transcoder_assert.svh"

module u8u16_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        empty,
	input logic                        pop,
	input logic [u8u16_pkg::UnitW-1:0] unit_out,
	input logic                        last_of_input,
	input logic                        truncated,
	input logic                        string_done
);
	import u8u16_pkg::*;

	// a truncated flush always closes its item and its string
	`U8U16_ASSERT_IMPLY(a_trunc_closes, clk, arst_n, !empty && truncated, string_done && last_of_input)
	// string_done only marks the final beat of an item
	`U8U16_ASSERT_IMPLY(a_done_last, clk, arst_n, !empty && string_done, last_of_input)
	// hold a stalled result beat
	`U8U16_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(unit_out) && $stable(last_of_input) && $stable(truncated) && $stable(string_done))

endmodule

bind utf8_utf16_transcoder u8u16_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.empty         (empty),
	.pop           (pop),
	.unit_out      (unit_out),
	.last_of_input (last_of_input),
	.truncated     (truncated),
	.string_done   (string_done)
);
